@@ hw/rtl/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the timed color crossfade block.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned LEN_W  = 15;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned NCH    = 3;

	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	localparam logic [IDX_W-1:0] CFG_FADE_START    = 2'd0;
	localparam logic [IDX_W-1:0] CFG_FADE_LENGTH   = 2'd1;
	localparam logic [IDX_W-1:0] CFG_FADE_DISABLED = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} tcc_div_stat_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DSTART = 6'b000010,
		S_DWAIT  = 6'b000100,
		S_SEL    = 6'b001000,
		S_MUL    = 6'b010000,
		S_RED    = 6'b100000
	} tcc_state_t;

endpackage

@@ hw/rtl/tcc_if.sv @@
// ----------------------------------------------------------------------------
// tcc_if
// Valid/ready channels for pixel items and blended results.
// ----------------------------------------------------------------------------
interface tcc_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_time;
	logic [7:0]  first_red;
	logic [7:0]  first_green;
	logic [7:0]  first_blue;
	logic [7:0]  second_red;
	logic [7:0]  second_green;
	logic [7:0]  second_blue;

	modport source (output valid, now_time, first_red, first_green, first_blue,
		second_red, second_green, second_blue, input ready);
	modport sink (input valid, now_time, first_red, first_green, first_blue,
		second_red, second_green, second_blue, output ready);
endinterface

interface tcc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       fade_done;

	modport source (output valid, out_red, out_green, out_blue, fade_done, input ready);
	modport sink (input valid, out_red, out_green, out_blue, fade_done, output ready);
endinterface

@@ hw/rtl/timed_color_crossfade.sv @@
// A transaction goes from S_SEL to the output register when the factor is 0 or
// 255, and through S_MUL and S_RED per channel when blending a cached factor.
// A new time stamp first passes S_DSTART and S_DWAIT when the bit-serial factor
// divider runs. The next transaction can be taken in the cycle after the result is
// loaded into the output register, which holds a stalled result while the next
// item runs. Reset clears cache and done flag, and resets control and fade state.
// ----------------------------------------------------------------------------
// timed_color_crossfade
// Time-driven RGB crossfade with cached blend factor and sticky done flag.
// ----------------------------------------------------------------------------
module timed_color_crossfade (
	input  logic                              clk,
	input  logic                              arst_n,
	tcc_item_if.sink                          item,
	tcc_result_if.source                      result,
	input  logic                              cfg_we,
	input  logic [tcc_pkg::IDX_W-1:0]         cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]         cfg_data
);
	localparam int unsigned CHI_W = $clog2(tcc_pkg::NCH);

	tcc_pkg::tcc_state_t          state_q;
	logic [tcc_pkg::TIME_W-1:0]   fade_start_q;
	logic [tcc_pkg::LEN_W-1:0]    fade_length_q;
	logic                         fade_disabled_q;
	logic [tcc_pkg::CH_W-1:0]     factor_q;
	logic [tcc_pkg::TIME_W-1:0]   cached_time_q;
	logic                         cache_valid_q;
	logic                         done_q;
	logic                         out_pend_q;
	logic [tcc_pkg::TIME_W-1:0]   elapsed_q;
	logic [CHI_W-1:0]             ch_q;
	logic [tcc_pkg::CH_W-1:0]     first_q  [tcc_pkg::NCH];
	logic [tcc_pkg::CH_W-1:0]     second_q [tcc_pkg::NCH];
	logic [tcc_pkg::CH_W-1:0]     res_q    [tcc_pkg::NCH];
	logic                         rvalid_q;
	logic [tcc_pkg::CH_W-1:0]     out_red_q;
	logic [tcc_pkg::CH_W-1:0]     out_green_q;
	logic [tcc_pkg::CH_W-1:0]     out_blue_q;
	logic                         out_done_q;

	logic                         accept;
	logic                         refresh;
	logic                         load_out;
	logic                         div_start;
	logic [tcc_pkg::TIME_W-1:0]   scaled;
	tcc_pkg::tcc_div_stat_t       div_stat;
	logic [tcc_pkg::CH_W-1:0]     div_factor;
	logic [tcc_pkg::CH_W-1:0]     blend_val;

	assign item.ready = (state_q == tcc_pkg::S_IDLE) && !out_pend_q;
	assign accept     = item.valid && item.ready;
	assign refresh    = !cache_valid_q || (item.now_time != cached_time_q);
	assign load_out   = out_pend_q && (!rvalid_q || result.ready);
	assign div_start  = (state_q == tcc_pkg::S_DSTART);
	assign scaled     = {elapsed_q[tcc_pkg::TIME_W-9:0], 8'h00} - elapsed_q;

	tcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scaled),
		.divisor  (fade_length_q),
		.stat     (div_stat),
		.factor   (div_factor)
	);

	tcc_blend u_blend (
		.clk   (clk),
		.en    (state_q == tcc_pkg::S_MUL),
		.a     (first_q[ch_q]),
		.b     (second_q[ch_q]),
		.f     (factor_q),
		.value (blend_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= tcc_pkg::S_IDLE;
			fade_start_q    <= '0;
			fade_length_q   <= tcc_pkg::LEN_W'(1);
			fade_disabled_q <= 1'b1;
			factor_q        <= '0;
			cached_time_q   <= '0;
			cache_valid_q   <= 1'b0;
			done_q          <= 1'b0;
			out_pend_q      <= 1'b0;
			rvalid_q        <= 1'b0;
			ch_q            <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tcc_pkg::CFG_FADE_START: begin
						fade_start_q <= cfg_data;
						done_q       <= 1'b0;
					end
					tcc_pkg::CFG_FADE_LENGTH: begin
						fade_length_q <= cfg_data[tcc_pkg::LEN_W-1:0];
						done_q        <= 1'b0;
					end
					tcc_pkg::CFG_FADE_DISABLED: fade_disabled_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (load_out) begin
				rvalid_q   <= 1'b1;
				out_pend_q <= 1'b0;
			end else if (result.ready) begin
				rvalid_q <= 1'b0;
			end

			unique case (state_q)
				tcc_pkg::S_IDLE: begin
					if (accept) begin
						if (refresh) begin
							cached_time_q <= item.now_time;
							cache_valid_q <= 1'b1;
							if (fade_disabled_q) begin
								factor_q <= '0;
								state_q  <= tcc_pkg::S_SEL;
							end else if (fade_length_q == '0) begin
								factor_q <= tcc_pkg::CH_MAX;
								state_q  <= tcc_pkg::S_SEL;
							end else begin
								state_q <= tcc_pkg::S_DSTART;
							end
						end else begin
							state_q <= tcc_pkg::S_SEL;
						end
					end
				end
				tcc_pkg::S_DSTART: state_q <= tcc_pkg::S_DWAIT;
				tcc_pkg::S_DWAIT: begin
					if (div_stat.done) begin
						factor_q <= div_factor;
						state_q  <= tcc_pkg::S_SEL;
					end
				end
				tcc_pkg::S_SEL: begin
					ch_q <= '0;
					if (factor_q == '0) begin
						out_pend_q <= 1'b1;
						state_q    <= tcc_pkg::S_IDLE;
					end else if (factor_q == tcc_pkg::CH_MAX) begin
						done_q     <= 1'b1;
						out_pend_q <= 1'b1;
						state_q    <= tcc_pkg::S_IDLE;
					end else begin
						state_q <= tcc_pkg::S_MUL;
					end
				end
				tcc_pkg::S_MUL: state_q <= tcc_pkg::S_RED;
				tcc_pkg::S_RED: begin
					if (ch_q == CHI_W'(tcc_pkg::NCH - 1)) begin
						out_pend_q <= 1'b1;
						state_q    <= tcc_pkg::S_IDLE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= tcc_pkg::S_MUL;
					end
				end
				default: state_q <= tcc_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_q   <= item.now_time - fade_start_q;
			first_q[0]  <= item.first_red;
			first_q[1]  <= item.first_green;
			first_q[2]  <= item.first_blue;
			second_q[0] <= item.second_red;
			second_q[1] <= item.second_green;
			second_q[2] <= item.second_blue;
		end
		if (state_q == tcc_pkg::S_SEL) begin
			for (int i = 0; i < tcc_pkg::NCH; i++) begin
				res_q[i] <= (factor_q == tcc_pkg::CH_MAX) ? second_q[i] : first_q[i];
			end
		end
		if (state_q == tcc_pkg::S_RED) begin
			res_q[ch_q] <= blend_val;
		end
		if (load_out) begin
			out_red_q   <= res_q[0];
			out_green_q <= res_q[1];
			out_blue_q  <= res_q[2];
			out_done_q  <= done_q;
		end
	end

	assign result.valid     = rvalid_q;
	assign result.out_red   = out_red_q;
	assign result.out_green = out_green_q;
	assign result.out_blue  = out_blue_q;
	assign result.fade_done = out_done_q;

endmodule

@@ hw/rtl/tcc_div.sv @@
// ----------------------------------------------------------------------------
// tcc_div
// Serial restoring divider, 32-bit dividend by 15-bit divisor, one bit/cycle.
// ----------------------------------------------------------------------------
module tcc_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [tcc_pkg::TIME_W-1:0]         dividend,
	input  logic [tcc_pkg::LEN_W-1:0]          divisor,
	output tcc_pkg::tcc_div_stat_t             stat,
	output logic [tcc_pkg::CH_W-1:0]           factor
);
	localparam int unsigned CNT_W = $clog2(tcc_pkg::TIME_W);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [tcc_pkg::TIME_W-1:0]   dvd_q;
	logic [tcc_pkg::LEN_W-1:0]    dvs_q;
	logic [tcc_pkg::LEN_W:0]      rem_q;
	logic [tcc_pkg::LEN_W:0]      rem_sh;
	logic [tcc_pkg::LEN_W+1:0]    trial;
	logic                         qbit;

	assign rem_sh = {rem_q[tcc_pkg::LEN_W-1:0], dvd_q[tcc_pkg::TIME_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign qbit   = ~trial[tcc_pkg::LEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(tcc_pkg::TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[tcc_pkg::TIME_W-2:0], qbit};
			rem_q <= qbit ? trial[tcc_pkg::LEN_W:0] : rem_sh;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	// saturate quotient at full scale
	assign factor = (|dvd_q[tcc_pkg::TIME_W-1:tcc_pkg::CH_W]) ? tcc_pkg::CH_MAX
		: dvd_q[tcc_pkg::CH_W-1:0];

endmodule

@@ hw/rtl/tcc_blend.sv @@
// ----------------------------------------------------------------------------
// tcc_blend
// Shared channel blend unit: weighted sum registered, then divide by 255.
// ----------------------------------------------------------------------------
module tcc_blend (
	input  logic                     clk,
	input  logic                     en,
	input  logic [tcc_pkg::CH_W-1:0] a,
	input  logic [tcc_pkg::CH_W-1:0] b,
	input  logic [tcc_pkg::CH_W-1:0] f,
	output logic [tcc_pkg::CH_W-1:0] value
);
	localparam int unsigned PW = 2 * tcc_pkg::CH_W;

	logic [PW-1:0]            prod_s1;
	logic                     nz_s1;
	logic [tcc_pkg::CH_W-1:0] fi;
	logic [PW-1:0]            sum;
	logic [PW-1:0]            adj;
	logic [tcc_pkg::CH_W-1:0] q;

	assign fi  = tcc_pkg::CH_MAX - f;
	assign sum = PW'(fi) * PW'(a) + PW'(f) * PW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= sum;
			nz_s1   <= (a != '0) || (b != '0);
		end
	end

	// x/255 for x <= 255*255
	assign adj   = prod_s1 + (prod_s1 >> tcc_pkg::CH_W) + PW'(1);
	assign q     = adj[PW-1:tcc_pkg::CH_W];
	assign value = (q == '0 && nz_s1) ? tcc_pkg::CH_W'(1) : q;

endmodule

@@ hw/rtl/tcc_chk.sv @@
// ----------------------------------------------------------------------------
// tcc_chk
// Port-level checks for the crossfade block, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic       fade_done
);

	// one transaction at a time: busy right after accepting
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous one in progress");

	// a result never rises in the cycle after its transaction is accepted
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(result_valid))
		else $error("result appeared without processing time");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_red)
		&& $stable(out_green) && $stable(out_blue) && $stable(fade_done))
		else $error("stalled result changed");

endmodule

bind timed_color_crossfade tcc_chk u_tcc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.out_red      (result.out_red),
	.out_green    (result.out_green),
	.out_blue     (result.out_blue),
	.fade_done    (result.fade_done)
);

@@ dv/crossfade_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crossfade_checker
// Watches the pixel and result channels and the register port. Keeps its own
// copy of the fade registers, the cached blend factor and the done flag,
// predicts each blended pixel and compares it field by field in order.
// ----------------------------------------------------------------------------
module crossfade_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	tcc_item_if                       item,
	tcc_result_if                     result,
	input  logic                      cfg_we,
	input  logic [tcc_pkg::IDX_W-1:0] cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        checked
);

	typedef struct packed {
		logic [tcc_pkg::CH_W-1:0] red;
		logic [tcc_pkg::CH_W-1:0] green;
		logic [tcc_pkg::CH_W-1:0] blue;
		logic                     done;
	} pixel_out_t;

	pixel_out_t expected_pixels[$];

	logic [tcc_pkg::TIME_W-1:0] start_q;
	logic [tcc_pkg::LEN_W-1:0]  length_q;
	logic                       disabled_q;
	logic [tcc_pkg::CH_W-1:0]   factor_q;
	logic [tcc_pkg::TIME_W-1:0] time_q;
	logic                       cached_q;
	logic                       done_q;

	function automatic logic [tcc_pkg::CH_W-1:0] fade_factor(
		input logic [tcc_pkg::TIME_W-1:0] now);
		logic [tcc_pkg::TIME_W-1:0] scaled;
		logic [tcc_pkg::TIME_W-1:0] quotient;
		if (disabled_q)
			return '0;
		if (length_q == '0)
			return tcc_pkg::CH_MAX;
		scaled = (now - start_q) * 32'(tcc_pkg::CH_MAX);
		quotient = scaled / 32'(length_q);
		return (quotient > 32'(tcc_pkg::CH_MAX)) ? tcc_pkg::CH_MAX
			: quotient[tcc_pkg::CH_W-1:0];
	endfunction

	function automatic logic [tcc_pkg::CH_W-1:0] mix_channel(
		input logic [tcc_pkg::CH_W-1:0] a, input logic [tcc_pkg::CH_W-1:0] b,
		input logic [tcc_pkg::CH_W-1:0] f);
		logic [31:0] sum;
		sum = ((32'(tcc_pkg::CH_MAX) - 32'(f)) * 32'(a) + 32'(f) * 32'(b))
			/ 32'(tcc_pkg::CH_MAX);
		if (sum == 0 && (a != '0 || b != '0))
			sum = 1;
		return sum[tcc_pkg::CH_W-1:0];
	endfunction

	function automatic pixel_out_t predict_pixel(input logic [tcc_pkg::TIME_W-1:0] now,
		input logic [tcc_pkg::CH_W-1:0] r1, input logic [tcc_pkg::CH_W-1:0] g1,
		input logic [tcc_pkg::CH_W-1:0] b1, input logic [tcc_pkg::CH_W-1:0] r2,
		input logic [tcc_pkg::CH_W-1:0] g2, input logic [tcc_pkg::CH_W-1:0] b2);
		pixel_out_t px;
		if (!cached_q || now != time_q) begin
			factor_q = fade_factor(now);
			time_q = now;
			cached_q = 1'b1;
		end
		if (factor_q == '0) begin
			px.red = r1;
			px.green = g1;
			px.blue = b1;
		end else if (factor_q == tcc_pkg::CH_MAX) begin
			done_q = 1'b1;
			px.red = r2;
			px.green = g2;
			px.blue = b2;
		end else begin
			px.red = mix_channel(r1, r2, factor_q);
			px.green = mix_channel(g1, g2, factor_q);
			px.blue = mix_channel(b1, b2, factor_q);
		end
		px.done = done_q;
		return px;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_out_t want;
		if (!arst_n) begin
			start_q = '0;
			length_q = tcc_pkg::LEN_W'(1);
			disabled_q = 1'b1;
			factor_q = '0;
			time_q = '0;
			cached_q = 1'b0;
			done_q = 1'b0;
			expected_pixels.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (result.valid && result.ready) begin
				checked++;
				if (expected_pixels.size() == 0) begin
					$error("result transaction with no pixel pending");
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("out_red", want.red, result.out_red);
					check_field("out_green", want.green, result.out_green);
					check_field("out_blue", want.blue, result.out_blue);
					check_field("fade_done", want.done, result.fade_done);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					tcc_pkg::CFG_FADE_START: begin
						start_q = cfg_data[tcc_pkg::TIME_W-1:0];
						done_q = 1'b0;
					end
					tcc_pkg::CFG_FADE_LENGTH: begin
						length_q = cfg_data[tcc_pkg::LEN_W-1:0];
						done_q = 1'b0;
					end
					tcc_pkg::CFG_FADE_DISABLED: begin
						disabled_q = cfg_data[0];
					end
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				expected_pixels.push_back(predict_pixel(item.now_time,
					item.first_red, item.first_green, item.first_blue,
					item.second_red, item.second_green, item.second_blue));
		end
		pending = expected_pixels.size();
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Crossfade testbench: directed pixels around fade start, end, wrap, cache
// reuse, zero length and disabled fading, then random fade set-ups with random
// pixels and idle gaps on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_PIXELS   = 100;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [tcc_pkg::IDX_W-1:0] cfg_index;
	logic [tcc_pkg::CFG_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int checked;
	int quiet_cycles;
	int stall_left;
	int reg_writes;
	bit src_steady;
	bit sink_steady;

	tcc_item_if   item_ch ();
	tcc_result_if result_ch ();

	timed_color_crossfade uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	crossfade_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [tcc_pkg::CH_W-1:0] rand_chan();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 25)
			return tcc_pkg::CH_MAX;
		if (r < 40)
			return tcc_pkg::CH_W'($urandom_range(1, 3));
		return tcc_pkg::CH_W'($urandom);
	endfunction

	function automatic logic [tcc_pkg::TIME_W-1:0] pick_time(
		input logic [tcc_pkg::TIME_W-1:0] start, input logic [tcc_pkg::LEN_W-1:0] length,
		input logic [tcc_pkg::TIME_W-1:0] last);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return start + $urandom_range(0, length);
		if (r < 60)
			return last;
		if (r < 70)
			return start - $urandom_range(1, 1000);
		if (r < 85)
			return $urandom;
		if (r < 95)
			return start + length + $urandom_range(0, 5000);
		return start;
	endfunction

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else begin
				result_ch.ready = 1'b1;
				if (!sink_steady)
					stall_left = idle_len();
			end
		end
	end

	task automatic write_reg(input logic [tcc_pkg::IDX_W-1:0] idx,
		input logic [tcc_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_pixel(input logic [tcc_pkg::TIME_W-1:0] now,
		input logic [tcc_pkg::CH_W-1:0] r1, input logic [tcc_pkg::CH_W-1:0] g1,
		input logic [tcc_pkg::CH_W-1:0] b1, input logic [tcc_pkg::CH_W-1:0] r2,
		input logic [tcc_pkg::CH_W-1:0] g2, input logic [tcc_pkg::CH_W-1:0] b2);
		int gap;
		gap = src_steady ? 0 : idle_len();
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid = 1'b0;
		end
		@(negedge clk);
		item_ch.valid = 1'b1;
		item_ch.now_time = now;
		item_ch.first_red = r1;
		item_ch.first_green = g1;
		item_ch.first_blue = b1;
		item_ch.second_red = r2;
		item_ch.second_green = g2;
		item_ch.second_blue = b2;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	initial begin
		logic [tcc_pkg::TIME_W-1:0] start;
		logic [tcc_pkg::LEN_W-1:0]  length;
		logic [tcc_pkg::TIME_W-1:0] now;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tcc_pkg::CFG_FADE_START;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.now_time = '0;
		item_ch.first_red = '0;
		item_ch.first_green = '0;
		item_ch.first_blue = '0;
		item_ch.second_red = '0;
		item_ch.second_green = '0;
		item_ch.second_blue = '0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		reg_writes = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fading disabled out of reset
		send_pixel(32'd0, 8'h00, 8'hFF, 8'h55, 8'hFF, 8'h00, 8'hAA);
		send_pixel(32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hAA, 8'h00, 8'hFF, 8'h55);
		wait_for_results();

		write_reg(tcc_pkg::CFG_FADE_DISABLED, 32'd0);
		write_reg(tcc_pkg::CFG_FADE_START, 32'd1000);
		write_reg(tcc_pkg::CFG_FADE_LENGTH, 32'd100);
		send_pixel(32'd1000, 8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(32'd1050, 8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h80);
		send_pixel(32'd1050, 8'h01, 8'hFE, 8'h00, 8'hFE, 8'h01, 8'h00);
		send_pixel(32'd1001, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h02);
		send_pixel(32'd1100, 8'hAA, 8'hBB, 8'hCC, 8'h11, 8'h22, 8'h33);
		send_pixel(32'd1099, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h00);
		// time before start wraps and saturates
		send_pixel(32'd999, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60);
		wait_for_results();

		// stale cache: same time reuses the saturated factor after a set-up
		write_reg(tcc_pkg::CFG_FADE_LENGTH, 32'd32767);
		send_pixel(32'd999, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_pixel(32'd1000 + 32'd32767, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06);
		send_pixel(32'd1000 + 32'd16000, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'hFF, 8'h80);
		wait_for_results();

		write_reg(tcc_pkg::CFG_FADE_LENGTH, 32'd0);
		send_pixel(32'd5, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		wait_for_results();

		write_reg(tcc_pkg::CFG_FADE_DISABLED, 32'd1);
		send_pixel(32'd1050, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h5A, 8'hA5);
		wait_for_results();

		write_reg(tcc_pkg::CFG_FADE_START, 32'hFFFF_FFFF);
		write_reg(tcc_pkg::CFG_FADE_LENGTH, 32'd1);
		write_reg(tcc_pkg::CFG_FADE_DISABLED, 32'd0);
		send_pixel(32'hFFFF_FFFF, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h7F, 8'h7F);
		send_pixel(32'd0, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h7F, 8'h7F);

		now = '0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_results();
			case (phase)
				0: start = '0;
				1: start = 32'hFFFF_FFFF;
				default: start = $urandom;
			endcase
			case (phase)
				2: length = tcc_pkg::LEN_W'(1);
				3: length = tcc_pkg::LEN_W'(32767);
				default: length = ($urandom_range(0, 1) != 0) ?
					tcc_pkg::LEN_W'($urandom_range(2, 300))
					: tcc_pkg::LEN_W'($urandom_range(1, 32767));
			endcase
			write_reg(tcc_pkg::CFG_FADE_START, start);
			write_reg(tcc_pkg::CFG_FADE_LENGTH, tcc_pkg::CFG_W'(length));
			write_reg(tcc_pkg::CFG_FADE_DISABLED, (phase == 5) ? 32'd1 : 32'd0);
			src_steady = (phase % 3 == 1);
			sink_steady = (phase % 3 == 2);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				now = pick_time(start, length, now);
				send_pixel(now, rand_chan(), rand_chan(), rand_chan(),
					rand_chan(), rand_chan(), rand_chan());
			end
		end

		wait_for_results();
		repeat (20) @(negedge clk);
		$display("Compared %0d pixels over %0d register writes: fade edges, wrap,",
			checked, reg_writes);
		$display("cache reuse, zero length, disabled fades and random set-ups with gaps");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_if.sv
hw/rtl/tcc_div.sv
hw/rtl/tcc_blend.sv
hw/rtl/timed_color_crossfade.sv
hw/rtl/tcc_chk.sv
dv/crossfade_checker.sv
dv/tb.sv
